### design/bmpw_pkg.sv
// Shared constants, types and field layout for the BMP stream writer.
package bmpw_pkg;

	localparam int unsigned MAX_WIDTH  = 4096;
	localparam int unsigned MAX_HEIGHT = 4096;

	localparam int unsigned DIM_W   = 13;
	localparam int unsigned W_W     = $clog2(MAX_WIDTH + 1);
	localparam int unsigned H_W     = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned LINE_W  = W_W + 2;
	localparam int unsigned IMG_W   = LINE_W + H_W;

	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_ALPHA  = CFG_IDX_W'(2);

	localparam int unsigned HDR24      = 54;
	localparam int unsigned HDR32      = 122;
	localparam int unsigned HDR_IDX_W  = $clog2((HDR32 + 3) / 4);
	localparam int unsigned HDR_WORDS  = 1 << HDR_IDX_W;
	localparam int unsigned HDR_BYTES  = 4 * HDR_WORDS;
	localparam int unsigned HDR24_LAST = (HDR24 + 3) / 4 - 1;
	localparam int unsigned HDR32_LAST = (HDR32 + 3) / 4 - 1;
	localparam int unsigned HDR24_TAIL = HDR24 - 4 * HDR24_LAST;
	localparam int unsigned HDR32_TAIL = HDR32 - 4 * HDR32_LAST;
	localparam int unsigned FILE_HDR   = 14;

	localparam logic [15:0] SIG_BM      = 16'h4D42;
	localparam logic [31:0] MASK_RED    = 32'h00ff0000;
	localparam logic [31:0] MASK_GREEN  = 32'h0000ff00;
	localparam logic [31:0] MASK_BLUE   = 32'h000000ff;
	localparam logic [31:0] MASK_ALPHA  = 32'hff000000;
	localparam logic [31:0] CS_WIN      = 32'h57696E20;
	localparam logic [31:0] BI_RGB      = 32'd0;
	localparam logic [31:0] BI_BITFIELD = 32'd3;

	typedef struct packed {
		logic [W_W-1:0]   width;
		logic [H_W-1:0]   height;
		logic             alpha;
		logic [COL_W-1:0] width_m1;
		logic [ROW_W-1:0] height_m1;
		logic [1:0]       pad;
		logic [IMG_W-1:0] img_size;
	} cfg_derived_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  count;
		logic        last;
	} hdr_chunk_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
	} pixel_t;

	typedef struct packed {
		logic [31:0] bytes;
		logic [2:0]  count;
		logic        last_of_run;
		logic        end_of_file;
	} chunk_t;

	typedef enum logic [1:0] {
		PH_PIX = 2'b01,
		PH_PAD = 2'b10
	} phase_t;

endpackage

### design/bmpw_pix_if.sv
// Pixel input channel.
interface bmpw_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] blue_value;
	logic [7:0] green_value;
	logic [7:0] red_value;
	logic [7:0] alpha_value;

	modport source(output valid, blue_value, green_value, red_value, alpha_value,
		input ready);
	modport sink(input valid, blue_value, green_value, red_value, alpha_value,
		output ready);
endinterface

### design/bmpw_chunk_if.sv
// Byte chunk output channel.
interface bmpw_chunk_if;
	logic        valid;
	logic        ready;
	logic [31:0] chunk_bytes;
	logic [2:0]  byte_count;
	logic        last_of_run;
	logic        end_of_file;

	modport source(output valid, chunk_bytes, byte_count, last_of_run, end_of_file,
		input ready);
	modport sink(input valid, chunk_bytes, byte_count, last_of_run, end_of_file,
		output ready);
endinterface

### design/bmpw_cfg_if.sv
// Configuration write channel.
interface bmpw_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bmpw_pkg::CFG_IDX_W-1:0]  index;
	logic [bmpw_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### design/bmpw_cfg.sv
// Configuration registers and the frame geometry derived from them.
module bmpw_cfg (
	input  logic                   clk,
	input  logic                   arst_n,
	bmpw_cfg_if.sink               cfg,
	output bmpw_pkg::cfg_derived_t geom,
	output logic                   frame_clr
);

	logic [bmpw_pkg::DIM_W-1:0]  width_q;
	logic [bmpw_pkg::DIM_W-1:0]  height_q;
	logic                        alpha_q;
	logic                        wr;
	logic [bmpw_pkg::W_W-1:0]    w_c;
	logic [bmpw_pkg::H_W-1:0]    h_c;
	logic [bmpw_pkg::LINE_W-1:0] pix_bytes;
	logic [bmpw_pkg::LINE_W-1:0] line_bytes;
	bmpw_pkg::cfg_derived_t      geom_q;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid && cfg.ready;
	assign frame_clr = wr && (cfg.index == bmpw_pkg::REG_IMAGE_WIDTH ||
		cfg.index == bmpw_pkg::REG_IMAGE_HEIGHT || cfg.index == bmpw_pkg::REG_WRITE_ALPHA);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bmpw_pkg::DIM_W'(1);
			height_q <= bmpw_pkg::DIM_W'(1);
			alpha_q  <= 1'b0;
		end else if (wr) begin
			unique case (cfg.index)
				bmpw_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg.data[bmpw_pkg::DIM_W-1:0];
				bmpw_pkg::REG_IMAGE_HEIGHT: height_q <= cfg.data[bmpw_pkg::DIM_W-1:0];
				bmpw_pkg::REG_WRITE_ALPHA:  alpha_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0)
			w_c = bmpw_pkg::W_W'(1);
		else if (32'(width_q) > bmpw_pkg::MAX_WIDTH)
			w_c = bmpw_pkg::W_W'(bmpw_pkg::MAX_WIDTH);
		else
			w_c = bmpw_pkg::W_W'(width_q);

		if (height_q == '0)
			h_c = bmpw_pkg::H_W'(1);
		else if (32'(height_q) > bmpw_pkg::MAX_HEIGHT)
			h_c = bmpw_pkg::H_W'(bmpw_pkg::MAX_HEIGHT);
		else
			h_c = bmpw_pkg::H_W'(height_q);

		if (alpha_q)
			pix_bytes = {w_c, 2'b00};
		else
			pix_bytes = {1'b0, w_c, 1'b0} + bmpw_pkg::LINE_W'(w_c);
		line_bytes = (pix_bytes + bmpw_pkg::LINE_W'(3)) & ~bmpw_pkg::LINE_W'(3);
	end

	always_ff @(posedge clk) begin
		geom_q.width     <= w_c;
		geom_q.height    <= h_c;
		geom_q.alpha     <= alpha_q;
		geom_q.width_m1  <= bmpw_pkg::COL_W'(w_c - bmpw_pkg::W_W'(1));
		geom_q.height_m1 <= bmpw_pkg::ROW_W'(h_c - bmpw_pkg::H_W'(1));
		geom_q.pad       <= 2'(line_bytes - pix_bytes);
		geom_q.img_size  <= bmpw_pkg::IMG_W'(line_bytes) * bmpw_pkg::IMG_W'(h_c);
	end

	assign geom = geom_q;

endmodule

### design/bmpw_hdr.sv
// File header assembly: selects one four-byte word of the BMP header.
module bmpw_hdr (
	input  bmpw_pkg::cfg_derived_t       geom,
	input  logic [bmpw_pkg::HDR_IDX_W-1:0] idx,
	output bmpw_pkg::hdr_chunk_t         chunk
);

	logic [7:0]  hb    [bmpw_pkg::HDR_BYTES];
	logic [31:0] words [bmpw_pkg::HDR_WORDS];
	logic [31:0] hlen;
	logic [31:0] img;
	logic [31:0] fsize;
	logic [31:0] info_len;
	logic [31:0] w32;
	logic [31:0] h32;
	logic [31:0] comp;
	logic [bmpw_pkg::HDR_IDX_W-1:0] last_idx;

	always_comb begin
		hlen     = geom.alpha ? 32'(bmpw_pkg::HDR32) : 32'(bmpw_pkg::HDR24);
		img      = 32'(geom.img_size);
		fsize    = hlen + img;
		info_len = hlen - 32'(bmpw_pkg::FILE_HDR);
		w32      = 32'(geom.width);
		h32      = 32'(geom.height);
		comp     = geom.alpha ? bmpw_pkg::BI_BITFIELD : bmpw_pkg::BI_RGB;

		for (int i = 0; i < bmpw_pkg::HDR_BYTES; i++) begin
			hb[i] = 8'h00;
		end
		hb[0]  = bmpw_pkg::SIG_BM[7:0];
		hb[1]  = bmpw_pkg::SIG_BM[15:8];
		hb[26] = 8'd1;
		hb[28] = geom.alpha ? 8'd32 : 8'd24;
		for (int k = 0; k < 4; k++) begin
			hb[2 + k]  = fsize[8*k +: 8];
			hb[10 + k] = hlen[8*k +: 8];
			hb[14 + k] = info_len[8*k +: 8];
			hb[18 + k] = w32[8*k +: 8];
			hb[22 + k] = h32[8*k +: 8];
			hb[30 + k] = comp[8*k +: 8];
			hb[34 + k] = img[8*k +: 8];
			if (geom.alpha) begin
				hb[54 + k] = bmpw_pkg::MASK_RED[8*k +: 8];
				hb[58 + k] = bmpw_pkg::MASK_GREEN[8*k +: 8];
				hb[62 + k] = bmpw_pkg::MASK_BLUE[8*k +: 8];
				hb[66 + k] = bmpw_pkg::MASK_ALPHA[8*k +: 8];
				hb[70 + k] = bmpw_pkg::CS_WIN[8*k +: 8];
			end
		end

		for (int i = 0; i < bmpw_pkg::HDR_WORDS; i++) begin
			words[i] = {hb[4*i + 3], hb[4*i + 2], hb[4*i + 1], hb[4*i]};
		end

		last_idx = geom.alpha ? bmpw_pkg::HDR_IDX_W'(bmpw_pkg::HDR32_LAST)
			: bmpw_pkg::HDR_IDX_W'(bmpw_pkg::HDR24_LAST);
		chunk.word = words[idx];
		chunk.last = (idx == last_idx);
		if (chunk.last)
			chunk.count = geom.alpha ? 3'(bmpw_pkg::HDR32_TAIL) : 3'(bmpw_pkg::HDR24_TAIL);
		else
			chunk.count = 3'd4;
	end

endmodule

### design/bmpw_emit.sv
// Pixel input register, chunk sequencer, frame counters and output register.
module bmpw_emit (
	input  logic                           clk,
	input  logic                           arst_n,
	bmpw_pix_if.sink                       pix,
	bmpw_chunk_if.source                   chunk,
	input  bmpw_pkg::cfg_derived_t         geom,
	input  logic                           frame_clr,
	input  bmpw_pkg::hdr_chunk_t           hdr,
	output logic [bmpw_pkg::HDR_IDX_W-1:0] hdr_idx
);

	bmpw_pkg::pixel_t              px_s1;
	logic                          vld_s1;
	bmpw_pkg::chunk_t              chunk_s2;
	logic                          vld_s2;
	logic                          hdr_done_q;
	logic [bmpw_pkg::HDR_IDX_W-1:0] hdr_idx_q;
	logic [bmpw_pkg::COL_W-1:0]    col_q;
	logic [bmpw_pkg::ROW_W-1:0]    row_q;
	bmpw_pkg::phase_t              phase_q;

	logic                          out_free;
	logic                          go;
	logic                          consume;
	logic                          row_end;
	logic                          frame_end;
	bmpw_pkg::chunk_t              nxt;
	logic                          hdr_done_n;
	logic [bmpw_pkg::HDR_IDX_W-1:0] hdr_idx_n;
	logic [bmpw_pkg::COL_W-1:0]    col_n;
	logic [bmpw_pkg::ROW_W-1:0]    row_n;
	bmpw_pkg::phase_t              phase_n;

	assign out_free  = !vld_s2 || chunk.ready;
	assign go        = vld_s1 && out_free;
	assign row_end   = (col_q == geom.width_m1);
	assign frame_end = row_end && (row_q == geom.height_m1);
	assign pix.ready = !vld_s1 || consume;
	assign hdr_idx   = hdr_idx_q;

	always_comb begin
		nxt        = '0;
		consume    = 1'b0;
		hdr_done_n = hdr_done_q;
		hdr_idx_n  = hdr_idx_q;
		col_n      = col_q;
		row_n      = row_q;
		phase_n    = phase_q;
		if (go) begin
			if (!hdr_done_q) begin
				nxt.bytes = hdr.word;
				nxt.count = hdr.count;
				if (hdr.last) begin
					hdr_done_n = 1'b1;
					hdr_idx_n  = '0;
				end else begin
					hdr_idx_n = hdr_idx_q + bmpw_pkg::HDR_IDX_W'(1);
				end
			end else begin
				unique case (phase_q)
					bmpw_pkg::PH_PIX: begin
						nxt.bytes = {geom.alpha ? px_s1.alpha : 8'h00, px_s1.red,
							px_s1.green, px_s1.blue};
						nxt.count = geom.alpha ? 3'd4 : 3'd3;
						if (row_end && geom.pad != 2'd0) begin
							phase_n = bmpw_pkg::PH_PAD;
						end else begin
							consume = 1'b1;
						end
					end
					bmpw_pkg::PH_PAD: begin
						nxt.count = {1'b0, geom.pad};
						consume   = 1'b1;
						phase_n   = bmpw_pkg::PH_PIX;
					end
					default: ;
				endcase
			end
		end
		if (consume) begin
			nxt.last_of_run = 1'b1;
			nxt.end_of_file = frame_end;
			if (row_end) begin
				col_n = '0;
				if (frame_end) begin
					row_n      = '0;
					hdr_done_n = 1'b0;
				end else begin
					row_n = row_q + bmpw_pkg::ROW_W'(1);
				end
			end else begin
				col_n = col_q + bmpw_pkg::COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			hdr_done_q <= 1'b0;
			hdr_idx_q  <= '0;
			col_q      <= '0;
			row_q      <= '0;
			phase_q    <= bmpw_pkg::PH_PIX;
		end else begin
			if (pix.valid && pix.ready)
				vld_s1 <= 1'b1;
			else if (consume)
				vld_s1 <= 1'b0;
			if (out_free)
				vld_s2 <= go;
			if (frame_clr) begin
				hdr_done_q <= 1'b0;
				hdr_idx_q  <= '0;
				col_q      <= '0;
				row_q      <= '0;
				phase_q    <= bmpw_pkg::PH_PIX;
			end else begin
				hdr_done_q <= hdr_done_n;
				hdr_idx_q  <= hdr_idx_n;
				col_q      <= col_n;
				row_q      <= row_n;
				phase_q    <= phase_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix.valid && pix.ready) begin
			px_s1.blue  <= pix.blue_value;
			px_s1.green <= pix.green_value;
			px_s1.red   <= pix.red_value;
			px_s1.alpha <= pix.alpha_value;
		end
		if (go)
			chunk_s2 <= nxt;
	end

	assign chunk.valid       = vld_s2;
	assign chunk.chunk_bytes = chunk_s2.bytes;
	assign chunk.byte_count  = chunk_s2.count;
	assign chunk.last_of_run = chunk_s2.last_of_run;
	assign chunk.end_of_file = chunk_s2.end_of_file;

endmodule

### design/bmp_stream_writer.sv
// Top level of the BMP stream writer: pixel stream in, BMP file bytes out.
//
// The pix channel takes one pixel per beat, bottom row first and left to right.
// The chunk channel gives one to four file bytes per beat, first byte in bits 7:0,
// with last_of_run on the final beat caused by a pixel and end_of_file on the
// final beat of the file. The cfg channel writes image width, height and the
// alpha mode; any such write restarts the frame, and is always ready.
// The first chunk of a pixel leaves through the pixel input register and then the output register.
// Unless the receiver stalls, one pixel per cycle is sustained. The first
// pixel of a frame is preceded by 14 header beats (24-bit) or 31 (32-bit), and a
// row whose length is not a multiple of four bytes adds a padding beat;
// during these the single pixel input register holds pix.ready low.
// Reset gives width 1, height 1, 24-bit mode and a fresh frame.
// When the receiver stalls, the output register holds its beat, the input
// register takes one more pixel if it is empty, and pix.ready is low until the beat goes.
module bmp_stream_writer (
	input logic          clk,
	input logic          arst_n,
	bmpw_cfg_if.sink     cfg,
	bmpw_pix_if.sink     pix,
	bmpw_chunk_if.source chunk
);

	bmpw_pkg::cfg_derived_t         geom;
	logic                           frame_clr;
	bmpw_pkg::hdr_chunk_t           hdr;
	logic [bmpw_pkg::HDR_IDX_W-1:0] hdr_idx;

	bmpw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.geom      (geom),
		.frame_clr (frame_clr)
	);

	bmpw_hdr u_hdr (
		.geom  (geom),
		.idx   (hdr_idx),
		.chunk (hdr)
	);

	bmpw_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.chunk     (chunk),
		.geom      (geom),
		.frame_clr (frame_clr),
		.hdr       (hdr),
		.hdr_idx   (hdr_idx)
	);

endmodule

### design/bmpw_checker.sv
// Port-level checks for the BMP stream writer and their binding.
module bmpw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_bytes,
	input logic [2:0]  out_count,
	input logic        out_last,
	input logic        out_eof
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_bytes) &&
		$stable(out_count) && $stable(out_last) && $stable(out_eof))
		else $error("output beat changed while stalled");

	a_count_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_count == 3'd1 && out_bytes[31:8] == 24'd0) ||
		(out_count == 3'd2 && out_bytes[31:16] == 16'd0) ||
		(out_count == 3'd3 && out_bytes[31:24] == 8'd0) || out_count == 3'd4)
		else $error("bad byte count or unused bytes not zero");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_eof |-> out_last)
		else $error("end of file not on the final beat of a pixel");

	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |=> out_valid)
		else $error("gap inside the beats of one pixel");

endmodule

bind bmp_stream_writer bmpw_checker u_bmpw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (chunk.valid),
	.out_ready (chunk.ready),
	.out_bytes (chunk.chunk_bytes),
	.out_count (chunk.byte_count),
	.out_last  (chunk.last_of_run),
	.out_eof   (chunk.end_of_file)
);

### test/tb_bmp_stream_writer.sv
// Self-checking testbench that streams pixels into the BMP writer and checks every output chunk.
`timescale 1ns / 1ps

class bmp_scoreboard;
	logic [bmpw_pkg::DIM_W-1:0] width_reg;
	logic [bmpw_pkg::DIM_W-1:0] height_reg;
	logic                       alpha_reg;
	bit                         header_sent;
	int unsigned                column;
	int unsigned                row;
	logic [7:0]                 hdr_bytes[bmpw_pkg::HDR32];
	bmpw_pkg::chunk_t           file_chunks[$];
	int                         errors;
	int                         pixels;
	int                         chunks;
	int                         files;

	function new();
		width_reg = 1;
		height_reg = 1;
		alpha_reg = 1'b0;
		restart_frame();
	endfunction

	function void restart_frame();
		header_sent = 1'b0;
		column = 0;
		row = 0;
	endfunction

	function int pending();
		return file_chunks.size();
	endfunction

	function void write_reg(logic [bmpw_pkg::CFG_IDX_W-1:0] idx,
		logic [bmpw_pkg::CFG_DATA_W-1:0] data);
		if (idx == bmpw_pkg::REG_IMAGE_WIDTH)
			width_reg = data[bmpw_pkg::DIM_W-1:0];
		else if (idx == bmpw_pkg::REG_IMAGE_HEIGHT)
			height_reg = data[bmpw_pkg::DIM_W-1:0];
		else if (idx == bmpw_pkg::REG_WRITE_ALPHA)
			alpha_reg = data[0];
		else
			return;
		restart_frame();
	endfunction

	function void put_le(int unsigned pos, logic [31:0] v, int unsigned n);
		for (int unsigned k = 0; k < n; k++)
			hdr_bytes[pos + k] = v[8*k +: 8];
	endfunction

	function void note_pixel(bmpw_pkg::pixel_t p);
		int unsigned w, h, bpp, line, pad, hlen, img, cnt;
		logic [31:0] word;
		bmpw_pkg::chunk_t run[$];
		bmpw_pkg::chunk_t c;
		w = (width_reg == 0) ? 1 : ((width_reg > bmpw_pkg::MAX_WIDTH) ?
			bmpw_pkg::MAX_WIDTH : width_reg);
		h = (height_reg == 0) ? 1 : ((height_reg > bmpw_pkg::MAX_HEIGHT) ?
			bmpw_pkg::MAX_HEIGHT : height_reg);
		bpp = alpha_reg ? 4 : 3;
		line = (w * bpp + 3) & ~32'd3;
		pad = line - w * bpp;
		if (!header_sent) begin
			hlen = alpha_reg ? bmpw_pkg::HDR32 : bmpw_pkg::HDR24;
			img = line * h;
			foreach (hdr_bytes[i])
				hdr_bytes[i] = 8'h00;
			put_le(0, bmpw_pkg::SIG_BM, 2);
			put_le(2, hlen + img, 4);
			put_le(10, hlen, 4);
			put_le(14, hlen - bmpw_pkg::FILE_HDR, 4);
			put_le(18, w, 4);
			put_le(22, h, 4);
			put_le(26, 1, 2);
			put_le(28, bpp * 8, 2);
			put_le(30, alpha_reg ? bmpw_pkg::BI_BITFIELD : bmpw_pkg::BI_RGB, 4);
			put_le(34, img, 4);
			if (alpha_reg) begin
				put_le(54, bmpw_pkg::MASK_RED, 4);
				put_le(58, bmpw_pkg::MASK_GREEN, 4);
				put_le(62, bmpw_pkg::MASK_BLUE, 4);
				put_le(66, bmpw_pkg::MASK_ALPHA, 4);
				put_le(70, bmpw_pkg::CS_WIN, 4);
			end
			for (int unsigned pos = 0; pos < hlen; pos += 4) begin
				cnt = (hlen - pos < 4) ? hlen - pos : 4;
				word = '0;
				for (int unsigned k = 0; k < cnt; k++)
					word[8*k +: 8] = hdr_bytes[pos + k];
				c = {word, 3'(cnt), 1'b0, 1'b0};
				run.push_back(c);
			end
			header_sent = 1'b1;
		end
		word = {alpha_reg ? p.alpha : 8'h00, p.red, p.green, p.blue};
		c = {word, 3'(bpp), 1'b0, 1'b0};
		run.push_back(c);
		if (column + 1 >= w) begin
			if (pad != 0) begin
				c = {32'h0, 3'(pad), 1'b0, 1'b0};
				run.push_back(c);
			end
			column = 0;
			if (row + 1 >= h) begin
				run[run.size() - 1].end_of_file = 1'b1;
				restart_frame();
				files++;
			end else begin
				row++;
			end
		end else begin
			column++;
		end
		run[run.size() - 1].last_of_run = 1'b1;
		foreach (run[i])
			file_chunks.push_back(run[i]);
		pixels++;
	endfunction

	task report(string msg);
		errors++;
		if (errors <= 40)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task check_chunk(bmpw_pkg::chunk_t got);
		bmpw_pkg::chunk_t want;
		if (file_chunks.size() == 0) begin
			report($sformatf("chunk %h (%0d bytes) with nothing expected",
				got.bytes, got.count));
			return;
		end
		want = file_chunks.pop_front();
		chunks++;
		if (got.bytes !== want.bytes)
			report($sformatf("chunk %0d bytes %h, expected %h", chunks, got.bytes, want.bytes));
		if (got.count !== want.count)
			report($sformatf("chunk %0d count %0d, expected %0d", chunks, got.count, want.count));
		if (got.last_of_run !== want.last_of_run)
			report($sformatf("chunk %0d last_of_run %b, expected %b", chunks,
				got.last_of_run, want.last_of_run));
		if (got.end_of_file !== want.end_of_file)
			report($sformatf("chunk %0d end_of_file %b, expected %b", chunks,
				got.end_of_file, want.end_of_file));
	endtask

	task check_empty();
		if (file_chunks.size() != 0)
			report($sformatf("%0d chunks never arrived", file_chunks.size()));
	endtask
endclass

module tb_bmp_stream_writer;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 120;
	localparam int RANDOM_PIXELS  = 380;

	typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	bmpw_cfg_if   cfg_bus();
	bmpw_pix_if   pix_bus();
	bmpw_chunk_if chunk_bus();

	bmp_scoreboard bmp_sb = new();

	int src_idle_pct;
	int snk_idle_pct;
	logic hold_chunks;
	int idle_cycles;
	int cfg_writes;
	int random_pixels;
	int phase;

	bmp_stream_writer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.pix(pix_bus),
		.chunk(chunk_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (chunk_bus.valid && chunk_bus.ready)
			bmp_sb.check_chunk({chunk_bus.chunk_bytes, chunk_bus.byte_count,
				chunk_bus.last_of_run, chunk_bus.end_of_file});
		chunk_bus.ready <= !hold_chunks && ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (pix_bus.valid && pix_bus.ready) || (chunk_bus.valid && chunk_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no beat for %0d cycles.", WATCHDOG_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	task automatic set_idle(idle_mode_t m);
		case (m)
			IDLE_NONE: begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			IDLE_SRC: begin
				src_idle_pct = 74;
				snk_idle_pct = 0;
			end
			IDLE_SNK: begin
				src_idle_pct = 0;
				snk_idle_pct = 74;
			end
			default: begin
				src_idle_pct = 9;
				snk_idle_pct = 9;
			end
		endcase
	endtask

	task automatic write_reg(logic [bmpw_pkg::CFG_IDX_W-1:0] idx,
		logic [bmpw_pkg::CFG_DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		bmp_sb.write_reg(idx, data);
		cfg_writes++;
	endtask

	task automatic program_frame(int unsigned w, int unsigned h, bit a);
		write_reg(bmpw_pkg::REG_IMAGE_WIDTH, ($urandom & 32'hFFFF_E000) | (w & 32'h1FFF));
		write_reg(bmpw_pkg::REG_IMAGE_HEIGHT, ($urandom & 32'hFFFF_E000) | (h & 32'h1FFF));
		write_reg(bmpw_pkg::REG_WRITE_ALPHA, ($urandom & 32'hFFFF_FFFE) | 32'(a));
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic write_unused_reg();
		write_reg(bmpw_pkg::CFG_IDX_W'($urandom_range(3, 255)), $urandom);
		cfg_bus.valid <= 1'b0;
	endtask

	function automatic bmpw_pkg::pixel_t pattern_pixel(int k);
		case (k % 4)
			0: return '0;
			1: return '1;
			2: return {8'h55, 8'hAA, 8'h0F, 8'hF0};
			default: return bmpw_pkg::pixel_t'($urandom);
		endcase
	endfunction

	task automatic send_pixel(bmpw_pkg::pixel_t p);
		if ($urandom_range(99) < src_idle_pct) begin
			pix_bus.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct)
				@(posedge clk);
		end
		pix_bus.valid <= 1'b1;
		pix_bus.blue_value <= p.blue;
		pix_bus.green_value <= p.green;
		pix_bus.red_value <= p.red;
		pix_bus.alpha_value <= p.alpha;
		do @(posedge clk); while (!pix_bus.ready);
		bmp_sb.note_pixel(p);
	endtask

	task automatic send_run(int n, bit patterned);
		for (int i = 0; i < n; i++)
			send_pixel(patterned ? pattern_pixel(i) : bmpw_pkg::pixel_t'($urandom));
		pix_bus.valid <= 1'b0;
	endtask

	task automatic drain();
		while (bmp_sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_phase();
		int unsigned w, h, n, first;
		bit a;
		a = $urandom_range(1);
		if ($urandom_range(9) == 0) begin
			w = $urandom_range(0, 8191);
			h = $urandom_range(0, 8191);
			n = $urandom_range(1, 6);
		end else begin
			w = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 7);
			h = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 4);
			n = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
			n = n + $urandom_range(0, n);
		end
		program_frame(w, h, a);
		if (n > 1 && $urandom_range(5) == 0) begin
			first = $urandom_range(1, n - 1);
			send_run(first, 1'b0);
			drain();
			write_unused_reg();
			send_run(n - first, 1'b0);
		end else begin
			send_run(n, 1'b0);
		end
		drain();
		random_pixels += n;
	endtask

	initial begin
		arst_n <= 1'b0;
		hold_chunks <= 1'b0;
		pix_bus.valid <= 1'b0;
		pix_bus.blue_value <= '0;
		pix_bus.green_value <= '0;
		pix_bus.red_value <= '0;
		pix_bus.alpha_value <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= '0;
		cfg_bus.data <= '0;
		set_idle(IDLE_NONE);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A single-pixel file straight out of reset, twice.
		send_run(2, 1'b1);
		drain();
		program_frame(2, 2, 1'b0);
		send_run(4, 1'b1);
		drain();
		program_frame(3, 1, 1'b1);
		send_run(3, 1'b1);
		drain();
		// A write to an unused index must not restart the frame.
		program_frame(3, 2, 1'b0);
		send_run(2, 1'b1);
		drain();
		write_unused_reg();
		send_run(4, 1'b1);
		drain();
		program_frame(0, 8191, 1'b1);
		send_run(2, 1'b1);
		drain();
		program_frame(8191, 0, 1'b0);
		send_run(2, 1'b1);
		drain();
		program_frame(4096, 4096, 1'b1);
		send_run(1, 1'b1);
		drain();

		phase = 0;
		while (random_pixels < RANDOM_PIXELS) begin
			set_idle(idle_mode_t'(phase % 4));
			if (phase == 5) begin
				set_idle(IDLE_NONE);
				program_frame(5, 6, 1'b1);
				fork
					begin
						hold_chunks <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						hold_chunks <= 1'b0;
					end
				join_none
				send_run(30, 1'b0);
				drain();
				random_pixels += 30;
			end else begin
				random_phase();
			end
			phase++;
		end

		drain();
		bmp_sb.check_empty();
		$display("Sent %0d pixels with %0d register writes over %0d phases of idling.",
			bmp_sb.pixels, cfg_writes, phase);
		$display("Checked %0d chunks and %0d complete files, including one long stall.",
			bmp_sb.chunks, bmp_sb.files);
		if (bmp_sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### sim.f
design/bmpw_pkg.sv
design/bmpw_pix_if.sv
design/bmpw_chunk_if.sv
design/bmpw_cfg_if.sv
design/bmpw_cfg.sv
design/bmpw_hdr.sv
design/bmpw_emit.sv
design/bmp_stream_writer.sv
design/bmpw_checker.sv
test/tb_bmp_stream_writer.sv
